// ===== sv/crcfr_pkg.sv =====
// Shared types, constants and the CRC byte update for the command frame receiver.
package crcfr_pkg;

	localparam int FRAME_BYTES = 24;
	localparam int CNT_W = $clog2(FRAME_BYTES + 2);
	localparam int ADDR_W = $clog2(FRAME_BYTES);
	localparam logic [CNT_W-1:0] COUNT_SAT = CNT_W'(FRAME_BYTES + 1);
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;
	localparam int CRC_FIRST = 1;
	localparam int CRC_LAST = 21;
	localparam int CRC_HI_POS = 22;
	localparam int CRC_LO_POS = 23;
	localparam int MODE_POS = 21;
	localparam int WIN_LO = 1;
	localparam int WIN_HI = 14;
	localparam int SUM_MIN_LEN = 2;

	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic [PADDR_W-3:0] REG_START_BYTE = '0;

	typedef enum logic [2:0] {
		ST_BAD_LEN    = 3'd0,
		ST_BAD_START  = 3'd1,
		ST_MOTION_OK  = 3'd2,
		ST_AIM_OK     = 3'd3,
		ST_CHECK_FAIL = 3'd4
	} status_t;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       is_idle;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] vx_bits;
		logic [31:0] vy_bits;
		logic [31:0] wz_bits;
		logic [7:0]  mode_value;
		logic [31:0] yaw_bits;
		logic [31:0] pitch_bits;
		logic [31:0] depth_bits;
	} out_item_t;

	// Snapshot of the burst checks, taken when the idle item is accepted.
	typedef struct packed {
		logic       len_ok;
		logic       start_ok;
		logic       crc_ok;
		logic       sum_len_ok;
		logic [7:0] sum;
	} chk_flags_t;

	// Reflected Modbus CRC-16 update for one byte, bitwise over eight steps.
	function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

// ===== sv/crc_checked_command_frame_receiver.sv =====
// Top level of the CRC-checked command frame receiver.
// The block takes one item per cycle on the byte channel: either a received serial byte or an
// idle-line event that closes the current burst. Data bytes produce no result; every idle item
// produces exactly one result (the frame memory is read into stage 1, then the decision loads
// the output register), so back-to-back items are taken at one per cycle as
// long as the result side keeps up. The frame bytes are written into a 24-entry synchronous
// memory as they arrive; the CRC-16 (init FFFF, reflected poly A001) over bytes 1..21, its
// comparison with bytes 22 and 23, and the running 8-bit sum for the aim check are all updated
// byte by byte, so at the idle item only the sum check byte (at position L-1, L being byte 2)
// has to be fetched from the memory. Only a burst of exactly 24 bytes whose first byte equals
// the start_byte register is checked: a CRC match latches the motion words (vx, vy, wz and the
// mode byte), otherwise a sum match latches the aim words (yaw, pitch, depth). Every result
// reports all held words after any latch caused by that burst. The start_byte register sits at
// byte address 0 of the APB port and should only be written while no burst is in flight.
module crc_checked_command_frame_receiver (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              byte_valid,
	output logic                              byte_ready,
	input  crcfr_pkg::in_item_t               byte_item,
	output logic                              res_valid,
	input  logic                              res_ready,
	output crcfr_pkg::out_item_t              res_item,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [crcfr_pkg::PADDR_W-1:0]     paddr,
	input  logic [crcfr_pkg::PDATA_W-1:0]     pwdata,
	output logic [crcfr_pkg::PDATA_W-1:0]     prdata,
	output logic                              pready
);

	// Configuration register.
	logic [7:0] start_q;
	logic       cfg_sel;

	assign pready = 1'b1;
	assign cfg_sel = (paddr[crcfr_pkg::PADDR_W-1:2] == crcfr_pkg::REG_START_BYTE);
	assign prdata = cfg_sel ? {{(crcfr_pkg::PDATA_W-8){1'b0}}, start_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
		end else if (psel && penable && pwrite && pready && cfg_sel) begin
			start_q <= pwdata[7:0];
		end
	end

	// Handshake and pipeline control.
	logic       acc;
	logic       acc_byte;
	logic       acc_idle;
	logic       valid_s1;
	logic       adv_s1;

	assign adv_s1 = valid_s1 && (!res_valid || res_ready);
	assign byte_ready = !valid_s1 || adv_s1;
	assign acc = byte_valid && byte_ready;
	assign acc_byte = acc && !byte_item.is_idle;
	assign acc_idle = acc && byte_item.is_idle;

	// Burst tracking state.
	logic [crcfr_pkg::CNT_W-1:0] cnt_q;
	logic [15:0]                 crc_q;
	logic                        crc_hi_ok_q;
	logic                        crc_lo_ok_q;
	logic [7:0]                  sum_q;
	logic [7:0]                  byte0_q;
	logic [7:0]                  mode_cand_q;
	logic [7:0]                  win_q [crcfr_pkg::WIN_LO:crcfr_pkg::WIN_HI];
	logic                        in_frame;
	logic [8:0]                  sum_limit;
	logic [7:0]                  len;

	assign in_frame = (cnt_q < crcfr_pkg::CNT_W'(crcfr_pkg::FRAME_BYTES));
	assign len = win_q[2];
	// A byte at position k belongs to the sum when k + 2 <= L.
	assign sum_limit = {{(9-crcfr_pkg::CNT_W){1'b0}}, cnt_q} + 9'd2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			crc_q <= crcfr_pkg::CRC_INIT;
			crc_hi_ok_q <= 1'b0;
			crc_lo_ok_q <= 1'b0;
		end else if (acc_idle) begin
			cnt_q <= '0;
			crc_q <= crcfr_pkg::CRC_INIT;
			crc_hi_ok_q <= 1'b0;
			crc_lo_ok_q <= 1'b0;
		end else if (acc_byte) begin
			if (cnt_q < crcfr_pkg::COUNT_SAT) begin
				cnt_q <= cnt_q + crcfr_pkg::CNT_W'(1);
			end
			if (cnt_q >= crcfr_pkg::CNT_W'(crcfr_pkg::CRC_FIRST) &&
			    cnt_q <= crcfr_pkg::CNT_W'(crcfr_pkg::CRC_LAST)) begin
				crc_q <= crcfr_pkg::crc_update(crc_q, byte_item.rx_byte);
			end
			if (cnt_q == crcfr_pkg::CNT_W'(crcfr_pkg::CRC_HI_POS)) begin
				crc_hi_ok_q <= (byte_item.rx_byte == crc_q[15:8]);
			end
			if (cnt_q == crcfr_pkg::CNT_W'(crcfr_pkg::CRC_LO_POS)) begin
				crc_lo_ok_q <= (byte_item.rx_byte == crc_q[7:0]);
			end
		end
	end

	// Payload-side capture: first byte, running sum, word window and mode byte.
	always_ff @(posedge clk) begin
		if (acc_byte) begin
			if (cnt_q == '0) begin
				byte0_q <= byte_item.rx_byte;
				sum_q <= byte_item.rx_byte;
			end else if (cnt_q <= crcfr_pkg::CNT_W'(2)) begin
				sum_q <= sum_q + byte_item.rx_byte;
			end else if (in_frame && sum_limit <= {1'b0, len}) begin
				sum_q <= sum_q + byte_item.rx_byte;
			end
			for (int i = crcfr_pkg::WIN_LO; i <= crcfr_pkg::WIN_HI; i++) begin
				if (cnt_q == crcfr_pkg::CNT_W'(i)) begin
					win_q[i] <= byte_item.rx_byte;
				end
			end
			if (cnt_q == crcfr_pkg::CNT_W'(crcfr_pkg::MODE_POS)) begin
				mode_cand_q <= byte_item.rx_byte;
			end
		end
	end

	// Frame memory: one write port for incoming bytes, one registered read port used only
	// by idle items. A byte and an idle item never share a cycle, so no forwarding is needed.
	logic [7:0]                   frame_mem [crcfr_pkg::FRAME_BYTES];
	logic [7:0]                   chk_byte_s1;
	logic [crcfr_pkg::ADDR_W-1:0] rd_addr;
	logic                         sum_len_ok;

	assign sum_len_ok = (len >= 8'(crcfr_pkg::SUM_MIN_LEN)) &&
	                    (len <= 8'(crcfr_pkg::FRAME_BYTES));
	assign rd_addr = sum_len_ok ? crcfr_pkg::ADDR_W'(len - 8'd1) : '0;

	always_ff @(posedge clk) begin
		if (acc_byte && in_frame) begin
			frame_mem[cnt_q[crcfr_pkg::ADDR_W-1:0]] <= byte_item.rx_byte;
		end
		if (acc_idle) begin
			chk_byte_s1 <= frame_mem[rd_addr];
		end
	end

	// Check snapshot for stage 1. Short lengths are summed from the captured head bytes.
	crcfr_pkg::chk_flags_t flags_d;
	crcfr_pkg::chk_flags_t flags_s1;

	always_comb begin
		flags_d.len_ok = (cnt_q == crcfr_pkg::CNT_W'(crcfr_pkg::FRAME_BYTES));
		flags_d.start_ok = (byte0_q == start_q);
		flags_d.crc_ok = crc_hi_ok_q && crc_lo_ok_q;
		flags_d.sum_len_ok = sum_len_ok;
		if (len == 8'd2) begin
			flags_d.sum = byte0_q;
		end else if (len == 8'd3) begin
			flags_d.sum = byte0_q + win_q[1];
		end else begin
			flags_d.sum = sum_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (acc_idle) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc_idle) begin
			flags_s1 <= flags_d;
		end
	end

	// Stage 1 decision. The word window cannot change while stage 1 waits, since no item
	// is taken then, and the one byte taken in the advancing cycle is the first of a burst.
	crcfr_pkg::status_t status_d;

	always_comb begin
		priority if (!flags_s1.len_ok) begin
			status_d = crcfr_pkg::ST_BAD_LEN;
		end else if (!flags_s1.start_ok) begin
			status_d = crcfr_pkg::ST_BAD_START;
		end else if (flags_s1.crc_ok) begin
			status_d = crcfr_pkg::ST_MOTION_OK;
		end else if (!flags_s1.sum_len_ok) begin
			status_d = crcfr_pkg::ST_CHECK_FAIL;
		end else if (flags_s1.sum == chk_byte_s1) begin
			status_d = crcfr_pkg::ST_AIM_OK;
		end else begin
			status_d = crcfr_pkg::ST_CHECK_FAIL;
		end
	end

	// Held command words and the output register.
	logic [31:0]         vx_q, vy_q, wz_q, yaw_q, pitch_q, depth_q;
	logic [7:0]          mode_q;
	crcfr_pkg::status_t  status_q;
	logic                res_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vx_q <= '0;
			vy_q <= '0;
			wz_q <= '0;
			mode_q <= '0;
			yaw_q <= '0;
			pitch_q <= '0;
			depth_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (adv_s1) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			if (adv_s1 && status_d == crcfr_pkg::ST_MOTION_OK) begin
				vx_q <= {win_q[4], win_q[3], win_q[2], win_q[1]};
				vy_q <= {win_q[8], win_q[7], win_q[6], win_q[5]};
				wz_q <= {win_q[12], win_q[11], win_q[10], win_q[9]};
				mode_q <= mode_cand_q;
			end
			if (adv_s1 && status_d == crcfr_pkg::ST_AIM_OK) begin
				yaw_q <= {win_q[6], win_q[5], win_q[4], win_q[3]};
				pitch_q <= {win_q[10], win_q[9], win_q[8], win_q[7]};
				depth_q <= {win_q[14], win_q[13], win_q[12], win_q[11]};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			status_q <= status_d;
		end
	end

	assign res_valid = res_valid_q;
	assign res_item.status = status_q;
	assign res_item.vx_bits = vx_q;
	assign res_item.vy_bits = vy_q;
	assign res_item.wz_bits = wz_q;
	assign res_item.mode_value = mode_q;
	assign res_item.yaw_bits = yaw_q;
	assign res_item.pitch_bits = pitch_q;
	assign res_item.depth_bits = depth_q;

endmodule

// ===== sv/crcfr_checker.sv =====
// Port-level checker for the command frame receiver, bound to the top level.
module crcfr_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          byte_valid,
	input logic                          byte_ready,
	input crcfr_pkg::in_item_t           byte_item,
	input logic                          res_valid,
	input logic                          res_ready,
	input crcfr_pkg::out_item_t          res_item,
	input logic                          psel,
	input logic                          penable,
	input logic                          pwrite,
	input logic [crcfr_pkg::PADDR_W-1:0] paddr,
	input logic [crcfr_pkg::PDATA_W-1:0] pwdata,
	input logic [crcfr_pkg::PDATA_W-1:0] prdata,
	input logic                          pready
);

	// A stalled result keeps its payload.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_item))
		else $error("result changed while stalled");

	// Status codes stay within the defined set.
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_item.status <= 3'(crcfr_pkg::ST_CHECK_FAIL))
		else $error("status out of range");

	// An accepted idle item is followed by a valid result.
	a_idle_result: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid && byte_ready && byte_item.is_idle |-> ##2 res_valid)
		else $error("idle item produced no result");

	// A written start byte reads back.
	a_cfg_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && pready && paddr[crcfr_pkg::PADDR_W-1:2] == '0
		|=> !(psel && !pwrite && paddr[crcfr_pkg::PADDR_W-1:2] == '0) ||
		    prdata[7:0] == $past(pwdata[7:0]))
		else $error("start byte readback mismatch");

endmodule

bind crc_checked_command_frame_receiver crcfr_checker u_crcfr_checker (.*);

// ===== sim/tb_top.sv =====
// Self-checking testbench for the CRC-checked command frame receiver.
`timescale 1ns / 100ps

module tb_top;
	import crcfr_pkg::*;

	// Frame layout as seen on the serial line.
	localparam int FRAME_LEN   = FRAME_BYTES;
	localparam int COUNT_CAP   = FRAME_LEN + 1;
	localparam int CRC_START   = 1;
	localparam int CRC_END     = 21;
	localparam int CRC_HI_BYTE = 22;
	localparam int CRC_LO_BYTE = 23;
	localparam int MODE_BYTE   = 21;
	localparam int LEN_BYTE    = 2;
	localparam logic [15:0] CRC_SEED   = 16'hFFFF;
	localparam logic [15:0] CRC_POLY_R = 16'hA001;

	// Run control.
	localparam int RANDOM_ITEMS  = 960;
	localparam int SETTLE_CYCLES = 4;
	localparam int HANG_LIMIT    = 2000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic byte_valid = 1'b0;
	logic byte_ready;
	in_item_t byte_item = '0;
	logic res_valid;
	logic res_ready = 1'b0;
	out_item_t res_item;

	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic pready;

	crc_checked_command_frame_receiver dut (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(byte_valid),
		.byte_ready(byte_ready),
		.byte_item(byte_item),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res_item(res_item),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Receiver-side mirror of the block: burst collection, running CRC, the held words
	// and the start byte register. Every accepted idle item pushes one expected report.
	logic [4:0]  rx_count;
	logic [7:0]  rx_frame [FRAME_LEN];
	logic [15:0] rx_crc;
	logic [7:0]  start_setting;
	out_item_t   held_words;
	out_item_t   report_q [$];

	// Bytes of the burst under construction, sent in order before the closing idle item.
	logic [7:0] burst_buf [$];

	// When set, neither side inserts gaps, so items and reports go back to back.
	bit no_gaps = 1'b0;

	int items_sent = 0;
	int reports_checked = 0;
	int fail_count = 0;
	int verdict_count [5];
	int hang_cycles = 0;

	// Reflected CRC-16 step for one byte, done one data bit at a time.
	function automatic logic [15:0] crc_step(logic [15:0] acc, logic [7:0] data);
		logic [15:0] r;
		r = acc;
		for (int n = 0; n < 8; n++) begin
			if (r[0] ^ data[n]) begin
				r = (r >> 1) ^ CRC_POLY_R;
			end else begin
				r = r >> 1;
			end
		end
		return r;
	endfunction

	function automatic logic [31:0] frame_word(int pos);
		return {rx_frame[pos+3], rx_frame[pos+2], rx_frame[pos+1], rx_frame[pos]};
	endfunction

	// Decides a closed burst and latches the held words the way the block should.
	function automatic status_t judge_burst();
		int span;
		logic [7:0] acc;
		if (rx_count != 5'(FRAME_LEN)) begin
			return ST_BAD_LEN;
		end
		if (rx_frame[0] != start_setting) begin
			return ST_BAD_START;
		end
		if ({rx_frame[CRC_HI_BYTE], rx_frame[CRC_LO_BYTE]} == rx_crc) begin
			held_words.vx_bits = frame_word(1);
			held_words.vy_bits = frame_word(5);
			held_words.wz_bits = frame_word(9);
			held_words.mode_value = rx_frame[MODE_BYTE];
			return ST_MOTION_OK;
		end
		// The aim check reads the length from byte 2 and sums the received bytes.
		span = rx_frame[LEN_BYTE];
		if (span < 2 || span > FRAME_LEN) begin
			return ST_CHECK_FAIL;
		end
		acc = 8'h00;
		for (int i = 0; i < span - 1; i++) begin
			acc = acc + rx_frame[i];
		end
		if (acc != rx_frame[span-1]) begin
			return ST_CHECK_FAIL;
		end
		held_words.yaw_bits = frame_word(3);
		held_words.pitch_bits = frame_word(7);
		held_words.depth_bits = frame_word(11);
		return ST_AIM_OK;
	endfunction

	function automatic void track_item(in_item_t it);
		status_t verdict;
		out_item_t report;
		if (!it.is_idle) begin
			// Bytes past the 24th are dropped; the count sticks one above a full frame.
			if (rx_count < 5'(FRAME_LEN)) begin
				rx_frame[rx_count] = it.rx_byte;
				if (rx_count >= 5'(CRC_START) && rx_count <= 5'(CRC_END)) begin
					rx_crc = crc_step(rx_crc, it.rx_byte);
				end
			end
			if (rx_count < 5'(COUNT_CAP)) begin
				rx_count++;
			end
		end else begin
			verdict = judge_burst();
			rx_count = '0;
			rx_crc = CRC_SEED;
			report = held_words;
			report.status = verdict;
			report_q.push_back(report);
			verdict_count[verdict]++;
		end
	endfunction

	// Sends one item: an optional gap with valid low, then valid held until accepted.
	task automatic send_item(in_item_t it);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 7);
		if (gap != 0) begin
			byte_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_valid <= 1'b1;
		byte_item <= it;
		do @(posedge clk); while (!byte_ready);
		items_sent++;
		track_item(it);
	endtask

	// Sends the bytes in the burst buffer and closes the burst with an idle item. The byte
	// carried by the idle item is random because the block must ignore it.
	task automatic send_burst();
		foreach (burst_buf[i]) begin
			send_item(in_item_t'{rx_byte: burst_buf[i], is_idle: 1'b0});
		end
		send_item(in_item_t'{rx_byte: 8'($urandom), is_idle: 1'b1});
	endtask

	// Fills a full-length frame behind the given lead byte; a negative pattern means random.
	task automatic fill_frame(logic [7:0] lead, int pattern);
		burst_buf = {};
		burst_buf.push_back(lead);
		for (int i = 1; i < FRAME_LEN; i++) begin
			burst_buf.push_back(pattern < 0 ? 8'($urandom) : 8'(pattern));
		end
	endtask

	task automatic seal_crc();
		logic [15:0] acc;
		acc = CRC_SEED;
		for (int i = CRC_START; i <= CRC_END; i++) begin
			acc = crc_step(acc, burst_buf[i]);
		end
		burst_buf[CRC_HI_BYTE] = acc[15:8];
		burst_buf[CRC_LO_BYTE] = acc[7:0];
	endtask

	// Makes the additive sum over bytes 0..span-2 match byte span-1. For the two shortest
	// spans the check byte overlaps the length byte or the lead, so byte 1 is adjusted.
	task automatic seal_sum(int span);
		logic [7:0] acc;
		burst_buf[LEN_BYTE] = 8'(span);
		if (span == 2) begin
			burst_buf[1] = burst_buf[0];
		end else if (span == 3) begin
			burst_buf[1] = 8'(span) - burst_buf[0];
		end else begin
			acc = 8'h00;
			for (int i = 0; i < span - 1; i++) begin
				acc = acc + burst_buf[i];
			end
			burst_buf[span-1] = acc;
		end
	endtask

	// Stops sending, waits for every outstanding report and lets the pipeline settle.
	task automatic drain();
		byte_valid <= 1'b0;
		while (report_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes start_byte between bursts and reads it back through the same port.
	task automatic write_start_byte(logic [7:0] value);
		drain();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {REG_START_BYTE, 2'b00};
		pwdata <= {24'h000000, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		start_setting = value;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata[7:0] !== value) begin
			$display("time %0t: start_byte readback mismatch, expected %h, actual %h",
				$time, value, prdata[7:0]);
			fail_count++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// The register comes out of reset as zero, so a zero-led frame is already checked.
	task automatic test_reset_defaults();
		fill_frame(8'h00, 8'h00);
		seal_crc();
		send_burst();
		fill_frame(8'h00, -1);
		seal_sum(16);
		send_burst();
	endtask

	// Empty, short, one-short, one-long and far overlong bursts all report wrong length.
	task automatic test_burst_lengths();
		burst_buf = {};
		send_burst();
		burst_buf = {8'h00};
		send_burst();
		fill_frame(8'h00, -1);
		seal_crc();
		void'(burst_buf.pop_back());
		send_burst();
		fill_frame(8'h00, -1);
		seal_crc();
		burst_buf.push_back(8'h5A);
		send_burst();
		fill_frame(8'h00, -1);
		seal_crc();
		repeat (16) burst_buf.push_back(8'($urandom));
		send_burst();
		// Back-to-back idle items with nothing between them.
		burst_buf = {};
		send_burst();
	endtask

	task automatic test_start_byte();
		write_start_byte(8'hFF);
		fill_frame(8'hFF, 8'hFF);
		seal_crc();
		send_burst();
		fill_frame(8'hFE, -1);
		seal_crc();
		send_burst();
		fill_frame(8'h7F, -1);
		seal_crc();
		send_burst();
	endtask

	// Aim frames at the length limits, lengths out of range and a broken sum.
	task automatic test_sum_check();
		int spans [4] = '{2, 3, 23, 24};
		int bad_spans [4] = '{0, 1, 25, 255};
		write_start_byte(8'h3C);
		foreach (spans[i]) begin
			fill_frame(8'h3C, -1);
			seal_sum(spans[i]);
			send_burst();
		end
		foreach (bad_spans[i]) begin
			fill_frame(8'h3C, -1);
			burst_buf[LEN_BYTE] = 8'(bad_spans[i]);
			send_burst();
		end
		fill_frame(8'h3C, -1);
		seal_sum(10);
		burst_buf[9] = burst_buf[9] ^ 8'h01;
		send_burst();
	endtask

	// Mostly well-formed frames with random content, mixed with corrupted frames, wrong
	// starts and noise bursts of random length. Each phase runs with its own start byte.
	task automatic test_random_traffic();
		logic [7:0] settings [4];
		int goal;
		int phase_goal;
		int shape;
		logic [7:0] lead;
		bit held_once;
		held_once = 1'b0;
		settings = '{8'($urandom_range(1, 254)), 8'h00, 8'hFF, 8'($urandom_range(1, 254))};
		goal = items_sent + RANDOM_ITEMS;
		for (int phase = 0; phase < 4; phase++) begin
			write_start_byte(settings[phase]);
			phase_goal = goal - RANDOM_ITEMS + (phase + 1) * RANDOM_ITEMS / 4;
			while (items_sent < phase_goal) begin
				no_gaps = ($urandom_range(0, 4) == 0);
				shape = $urandom_range(0, 9);
				lead = start_setting;
				if (shape == 7) begin
					lead = start_setting ^ 8'($urandom_range(1, 255));
				end
				fill_frame(lead, -1);
				case (shape)
					0, 1, 2, 3, 7: begin
						seal_crc();
					end
					4, 5: begin
						seal_sum($urandom_range(2, FRAME_LEN));
					end
					8: begin
						burst_buf = burst_buf[0:$urandom_range(0, FRAME_LEN - 1)];
						if ($urandom_range(0, 1)) begin
							burst_buf = {};
						end else if ($urandom_range(0, 1)) begin
							repeat ($urandom_range(1, 8)) burst_buf.push_back(8'($urandom));
						end
					end
					9: begin
						// A single flipped bit always breaks the CRC.
						seal_crc();
						burst_buf[$urandom_range(1, FRAME_LEN - 1)] ^= 8'(1 << $urandom_range(0, 7));
					end
					default: begin
					end
				endcase
				send_burst();
				// Once, halfway through, hold the sender until every report is back.
				if (phase == 1 && !held_once && items_sent >= phase_goal - RANDOM_ITEMS / 8) begin
					drain();
					held_once = 1'b1;
				end
			end
		end
		no_gaps = 1'b0;
	endtask

	// The result side draws a fresh stall for every report.
	initial begin
		int stall;
		forever begin
			stall = no_gaps ? 0 : $urandom_range(0, 7);
			if (stall != 0) begin
				res_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_ready <= 1'b1;
			do @(posedge clk); while (!(res_valid && res_ready));
		end
	end

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("time %0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			fail_count++;
		end
	endtask

	// Compares every accepted report with the oldest expected one.
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && res_valid && res_ready) begin
			if (report_q.size() == 0) begin
				$display("time %0t: unexpected report, expected none, actual %h", $time, res_item);
				fail_count++;
			end else begin
				want = report_q.pop_front();
				check_field("status", 32'(want.status), 32'(res_item.status));
				check_field("vx_bits", want.vx_bits, res_item.vx_bits);
				check_field("vy_bits", want.vy_bits, res_item.vy_bits);
				check_field("wz_bits", want.wz_bits, res_item.wz_bits);
				check_field("mode_value", 32'(want.mode_value), 32'(res_item.mode_value));
				check_field("yaw_bits", want.yaw_bits, res_item.yaw_bits);
				check_field("pitch_bits", want.pitch_bits, res_item.pitch_bits);
				check_field("depth_bits", want.depth_bits, res_item.depth_bits);
				reports_checked++;
			end
		end
	end

	// Ends the run if nothing moves on either channel or the register port for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((byte_valid && byte_ready) || (res_valid && res_ready) || psel) begin
				hang_cycles = 0;
			end else begin
				hang_cycles++;
			end
			if (hang_cycles >= HANG_LIMIT) begin
				$display("time %0t: no progress for %0d cycles, %0d reports outstanding",
					$time, hang_cycles, report_q.size());
				$display("Some tests failed");
				$finish;
			end
		end
	end

	initial begin
		rx_count = '0;
		rx_crc = CRC_SEED;
		start_setting = 8'h00;
		held_words = '0;
		foreach (rx_frame[i]) rx_frame[i] = 8'h00;
		foreach (verdict_count[i]) verdict_count[i] = 0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_burst_lengths();
		test_start_byte();
		test_sum_check();
		test_random_traffic();

		drain();
		repeat (2 * SETTLE_CYCLES) @(posedge clk);

		$display("Sent %0d items and checked %0d reports: %0d motion, %0d aim, %0d rejected.",
			items_sent, reports_checked, verdict_count[ST_MOTION_OK], verdict_count[ST_AIM_OK],
			verdict_count[ST_BAD_LEN] + verdict_count[ST_BAD_START]
			+ verdict_count[ST_CHECK_FAIL]);
		$display("Start byte ran at its reset value, 00, FF and random settings, with gaps.");
		if (fail_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
